### design/assert_macros.svh
// Assertion shorthands for the deframer, used by rsd_core.
// Each use expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RSD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication.
`define RSD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

### design/rsd_pkg.sv
package rsd_pkg;

  // Parser phase, one-hot.
  typedef enum logic [4:0] {
    PH_HDR  = 5'b00001,
    PH_FHDR = 5'b00010,
    PH_PAY  = 5'b00100,
    PH_SKIP = 5'b01000,
    PH_IDLE = 5'b10000
  } phase_t;

  // Byte classes.
  localparam logic [1:0] CLS_RECORD_HDR = 2'd0;
  localparam logic [1:0] CLS_FIELD_HDR  = 2'd1;
  localparam logic [1:0] CLS_PAYLOAD    = 2'd2;
  localparam logic [1:0] CLS_SKIP       = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_SHORT_FHDR = 2'd1;
  localparam logic [1:0] ERR_SHORT_EXT  = 2'd2;
  localparam logic [1:0] ERR_OVERRUN    = 2'd3;

  localparam logic [31:0] TAG_EXT   = 32'h5858_5858;
  localparam logic [31:0] TAG_GROUP = 32'h5055_5247;
  localparam logic [15:0] EXT_LEN   = 16'd4;

  // Compressed flag 0x00040000 lives in flags byte 2 (header byte 10), bit 2.
  localparam logic [4:0] FLAG_BYTE_POS   = 5'd10;
  localparam int unsigned FLAG_COMP_BIT  = 2;

  localparam logic [4:0] HDR_SIZE_MIN   = 5'd20;
  localparam logic [4:0] HDR_SIZE_MAX   = 5'd24;
  localparam logic [4:0] HDR_SIZE_RESET = 5'd24;

  // Field header positions in the byte counter.
  localparam logic [4:0] FHDR_LAST     = 5'd5;
  localparam logic [4:0] EXT_HDR_LAST  = 5'd15;
  localparam logic [4:0] EXT_SIZE_FIRST = 5'd6;
  localparam logic [4:0] EXT_SIZE_LAST = 5'd9;
  localparam logic [31:0] FHDR_BYTES   = 32'd6;
  localparam logic [31:0] EXT_TAIL_MIN = 32'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_start;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  byte_class;
    logic [31:0] field_type;
    logic        field_first;
    logic        field_last;
    logic        record_end;
    logic [1:0]  error_code;
  } result_t;

endpackage

### design/record_subfield_deframer.sv
// channel  dir  handshake            payload
// in       in   in_valid/in_ready    data_byte, record_start
// out      out  out_valid/out_ready  out_byte, byte_class, field_type, field_first,
//                                    field_last, record_end, error_code
// cfg      in   cfg_valid/cfg_ready  cfg_data (header_size)
//
// One beat in, one beat out, one beat per cycle sustained while out_ready stays high;
// each byte passes the input register, then the parse logic into the result register.
// The parse state updates when a byte moves from the input register to the result
// register, so each byte sees the state left by the one before it.
// Sync reset clears all control state and sets header_size to 24; no clearing pass.
// With out_ready low the result holds and one more beat waits in the input register;
// in_ready then drops in the same cycle.
module record_subfield_deframer (
  input  logic        clk,
  input  logic        rst,
  // input bytes
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        record_start,
  // classified bytes
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  byte_class,
  output logic [31:0] field_type,
  output logic        field_first,
  output logic        field_last,
  output logic        record_end,
  output logic [1:0]  error_code,
  // header_size register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);
  import rsd_pkg::*;

  logic       item_valid;
  item_t      item;
  logic       can_load;
  logic       fire;
  result_t    res_comb;
  result_t    res_q;
  logic [4:0] header_size;

  // Config writes must land only while the pipe is empty; the block does not enforce this and is always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_size <= HDR_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      header_size <= cfg_data;
    end
  end

  // A byte is parsed when it leaves the input register.
  assign fire = item_valid && can_load;

  rsd_in_reg u_in (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .record_start (record_start),
    .advance      (can_load),
    .item_valid   (item_valid),
    .item         (item)
  );

  rsd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (item),
    .header_size (header_size),
    .result      (res_comb)
  );

  rsd_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .result_in  (res_comb),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_out (res_q)
  );

  assign out_byte    = res_q.out_byte;
  assign byte_class  = res_q.byte_class;
  assign field_type  = res_q.field_type;
  assign field_first = res_q.field_first;
  assign field_last  = res_q.field_last;
  assign record_end  = res_q.record_end;
  assign error_code  = res_q.error_code;

endmodule

### design/rsd_in_reg.sv
module rsd_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    data_byte,
  input  logic          record_start,
  input  logic          advance,
  output logic          item_valid,
  output rsd_pkg::item_t item
);
  import rsd_pkg::*;

  // Empty, or being drained this cycle.
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.data_byte    <= data_byte;
      item.record_start <= record_start;
    end
  end

endmodule

### design/rsd_core.sv
`include "assert_macros.svh"

module rsd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  rsd_pkg::item_t   item,
  input  logic [4:0]       header_size,
  output rsd_pkg::result_t result
);
  import rsd_pkg::*;

  // Parse state
  phase_t      phase;
  logic [4:0]  hcnt;
  logic [31:0] record_type;
  logic        skip_record;
  logic [31:0] rec_rem;
  logic        pend_valid;
  logic [47:0] fhb;
  logic [31:0] pend_size;
  logic [31:0] cur_type;
  logic [31:0] fld_rem;

  phase_t      phase_next;
  logic [4:0]  hcnt_next;
  logic [31:0] record_type_next;
  logic        skip_record_next;
  logic [31:0] rec_rem_next;
  logic        pend_valid_next;
  logic [47:0] fhb_next;
  logic [31:0] pend_size_next;
  logic [31:0] cur_type_next;
  logic [31:0] fld_rem_next;

  // View of the state after an optional record-start clear
  phase_t      ph_c;
  logic [4:0]  c;
  logic [31:0] rtype_c;
  logic        skip_c;
  logic [31:0] rr_c;
  logic        pv_c;

  logic [4:0]  hs;
  logic [7:0]  b;
  logic [31:0] rr_dec;
  logic [31:0] rr_sat;
  logic [31:0] fr_sat;
  logic [47:0] fhb_shift;
  logic [31:0] fh_type;
  logic [15:0] fh_len;
  logic [31:0] fsize;
  logic        hdr_done;

  assign b = item.data_byte;

  always_comb begin
    if (header_size < HDR_SIZE_MIN) begin
      hs = HDR_SIZE_MIN;
    end else if (header_size > HDR_SIZE_MAX) begin
      hs = HDR_SIZE_MAX;
    end else begin
      hs = header_size;
    end
  end

  assign ph_c    = item.record_start ? PH_HDR : phase;
  assign c       = item.record_start ? 5'd0 : hcnt;
  assign rtype_c = item.record_start ? 32'd0 : record_type;
  assign skip_c  = item.record_start ? 1'b0 : skip_record;
  assign rr_c    = item.record_start ? 32'd0 : rec_rem;
  assign pv_c    = item.record_start ? 1'b0 : pend_valid;

  assign rr_dec    = rr_c - 32'd1;
  assign rr_sat    = rr_c - {31'd0, (rr_c != 32'd0)};
  assign fr_sat    = fld_rem - {31'd0, (fld_rem != 32'd0)};
  assign fhb_shift = {b, fhb[47:8]};
  assign fh_type   = fhb_shift[31:0];
  assign fh_len    = fhb_shift[47:32];
  assign fsize     = pv_c ? pend_size : {16'd0, fh_len};
  assign hdr_done  = ({1'b0, c} + 6'd1) >= {1'b0, hs};

  always_comb begin
    phase_next       = ph_c;
    hcnt_next        = c;
    record_type_next = rtype_c;
    skip_record_next = skip_c;
    rec_rem_next     = rr_c;
    pend_valid_next  = pv_c;
    fhb_next         = fhb;
    pend_size_next   = pend_size;
    cur_type_next    = cur_type;
    fld_rem_next     = fld_rem;

    result.out_byte    = b;
    result.byte_class  = CLS_SKIP;
    result.field_type  = 32'd0;
    result.field_first = 1'b0;
    result.field_last  = 1'b0;
    result.record_end  = 1'b0;
    result.error_code  = ERR_NONE;

    unique case (ph_c)
      PH_HDR: begin
        result.byte_class = CLS_RECORD_HDR;
        if (c < 5'd4) begin
          record_type_next[{c[1:0], 3'b000} +: 8] = rtype_c[{c[1:0], 3'b000} +: 8] | b;
        end else if (c < 5'd8) begin
          rec_rem_next[{c[1:0], 3'b000} +: 8] = rr_c[{c[1:0], 3'b000} +: 8] | b;
        end else if (c == FLAG_BYTE_POS && b[FLAG_COMP_BIT]) begin
          skip_record_next = 1'b1;
        end
        if (hdr_done) begin
          if (record_type_next == TAG_GROUP) begin
            skip_record_next = 1'b1;
          end
          hcnt_next = 5'd0;
          if (rec_rem_next == 32'd0) begin
            result.record_end = 1'b1;
            phase_next        = PH_IDLE;
          end else begin
            phase_next = skip_record_next ? PH_SKIP : PH_FHDR;
          end
        end else begin
          hcnt_next = c + 5'd1;
        end
      end

      PH_FHDR: begin
        rec_rem_next = rr_dec;
        if (c == 5'd0 && rr_c < FHDR_BYTES) begin
          result.error_code = ERR_SHORT_FHDR;
          if (rr_dec == 32'd0) begin
            result.record_end = 1'b1;
            phase_next        = PH_IDLE;
          end else begin
            phase_next = PH_SKIP;
          end
        end else begin
          result.byte_class = CLS_FIELD_HDR;
          fhb_next          = fhb_shift;
          if (c == FHDR_LAST || c >= EXT_HDR_LAST) begin
            if (c == FHDR_LAST && fh_type == TAG_EXT && fh_len == EXT_LEN) begin
              if (rr_dec < EXT_TAIL_MIN) begin
                result.error_code = ERR_SHORT_EXT;
                if (rr_dec == 32'd0) begin
                  result.record_end = 1'b1;
                  phase_next        = PH_IDLE;
                end else begin
                  phase_next = PH_SKIP;
                end
              end else begin
                pend_valid_next = 1'b1;
                pend_size_next  = 32'd0;
                hcnt_next       = EXT_SIZE_FIRST;
              end
            end else begin
              cur_type_next = fh_type;
              if (fsize > rr_dec) begin
                result.error_code = ERR_OVERRUN;
                if (rr_dec == 32'd0) begin
                  result.record_end = 1'b1;
                  phase_next        = PH_IDLE;
                end else begin
                  phase_next = PH_SKIP;
                end
              end else begin
                fld_rem_next    = fsize;
                hcnt_next       = 5'd0;
                pend_valid_next = 1'b0;
                if (fsize != 32'd0) begin
                  phase_next = PH_PAY;
                end else if (rr_dec == 32'd0) begin
                  // empty field closes the record
                  result.record_end = 1'b1;
                  phase_next        = PH_IDLE;
                end else begin
                  phase_next = PH_FHDR;
                end
              end
            end
          end else begin
            // bytes 6..9 after an extended header carry the 32-bit size
            if (c >= EXT_SIZE_FIRST && c <= EXT_SIZE_LAST) begin
              pend_size_next[{c[1:0] - 2'd2, 3'b000} +: 8] = b;
            end
            hcnt_next = c + 5'd1;
          end
        end
      end

      PH_PAY: begin
        result.byte_class  = CLS_PAYLOAD;
        result.field_type  = cur_type;
        result.field_first = (c == 5'd0);
        hcnt_next          = 5'd1;
        fld_rem_next       = fr_sat;
        rec_rem_next       = rr_sat;
        if (fr_sat == 32'd0) begin
          result.field_last = 1'b1;
          hcnt_next         = 5'd0;
          pend_valid_next   = 1'b0;
          if (rr_sat == 32'd0) begin
            result.record_end = 1'b1;
            phase_next        = PH_IDLE;
          end else begin
            phase_next = PH_FHDR;
          end
        end
      end

      PH_SKIP: begin
        rec_rem_next = rr_sat;
        if (rr_sat == 32'd0) begin
          result.record_end = 1'b1;
          phase_next        = PH_IDLE;
        end
      end

      PH_IDLE: begin
        phase_next = PH_IDLE;
      end

      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR;
      hcnt        <= 5'd0;
      record_type <= 32'd0;
      skip_record <= 1'b0;
      rec_rem     <= 32'd0;
      pend_valid  <= 1'b0;
    end else if (fire) begin
      phase       <= phase_next;
      hcnt        <= hcnt_next;
      record_type <= record_type_next;
      skip_record <= skip_record_next;
      rec_rem     <= rec_rem_next;
      pend_valid  <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      fhb       <= fhb_next;
      pend_size <= pend_size_next;
      cur_type  <= cur_type_next;
      fld_rem   <= fld_rem_next;
    end
  end

  // An error always leads into discard or the end of the record.
  `RSD_ASSERT_NXT(a_err_discards, fire && (result.error_code != ERR_NONE), (phase == PH_SKIP) || (phase == PH_IDLE))
  // A field never reaches past its record.
  `RSD_ASSERT_IMP(a_field_in_record, phase == PH_PAY, rec_rem >= fld_rem)
  // A record cannot end in the middle of a field payload.
  `RSD_ASSERT_IMP(a_end_closes_field, fire && result.record_end && (result.byte_class == CLS_PAYLOAD), result.field_last)

endmodule

### design/rsd_out_reg.sv
module rsd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  rsd_pkg::result_t result_in,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output rsd_pkg::result_t result_out
);
  import rsd_pkg::*;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

### dv/record_subfield_deframer_test.sv
`timescale 1ns / 1ps

module record_subfield_deframer_test;
  import rsd_pkg::*;

  // Quiet cycles (no beat on any channel) before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;
  // Settle time after the last result.
  localparam int unsigned TAIL_CYCLES    = 12;
  // Flags word bit that marks a compressed record (flags byte 2, bit 2).
  localparam logic [31:0] COMPRESSED_FLAG = 32'h0004_0000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        record_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic [1:0]  byte_class;
  logic [31:0] field_type;
  logic        field_first;
  logic        field_last;
  logic        record_end;
  logic [1:0]  error_code;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;

  record_subfield_deframer i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .record_start (record_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .byte_class   (byte_class),
    .field_type   (field_type),
    .field_first  (field_first),
    .field_last   (field_last),
    .record_end   (record_end),
    .error_code   (error_code),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parser mirror. Advanced once per accepted input beat, in acceptance order.
  // ---------------------------------------------------------------------------
  logic [4:0]  hdr_size_reg;   // raw register value, clamped on use
  phase_t      parse_ph;
  logic [4:0]  hdr_cnt;        // byte position inside record / field header
  logic [31:0] rec_tag;
  logic        rec_skip;
  logic [31:0] rec_left;       // data bytes still owed by the record
  logic [47:0] fhdr_shift;     // last six field header bytes, oldest at LSB
  logic [31:0] ext_size;
  logic        ext_pending;
  logic [31:0] fld_tag;
  logic [31:0] fld_left;
  logic        err_seen;

  result_t predicted[$];       // classified beats still owed by the block

  function automatic logic [4:0] eff_hdr_size();
    if (hdr_size_reg < HDR_SIZE_MIN) return HDR_SIZE_MIN;
    if (hdr_size_reg > HDR_SIZE_MAX) return HDR_SIZE_MAX;
    return hdr_size_reg;
  endfunction

  function automatic void clear_parse();
    parse_ph    = PH_HDR;
    hdr_cnt     = '0;
    rec_tag     = '0;
    rec_skip    = 1'b0;
    rec_left    = '0;
    fhdr_shift  = '0;
    ext_size    = '0;
    ext_pending = 1'b0;
    fld_tag     = '0;
    fld_left    = '0;
    err_seen    = 1'b0;
  endfunction

  // Error found: throw away what is left of the record. Returns record_end.
  function automatic logic discard_rest();
    err_seen = 1'b1;
    if (rec_left == 0) begin
      parse_ph = PH_IDLE;
      return 1'b1;
    end
    parse_ph = PH_SKIP;
    return 1'b0;
  endfunction

  // Field done: next field header or end of record. Returns record_end.
  function automatic logic close_field();
    hdr_cnt     = '0;
    ext_pending = 1'b0;
    if (rec_left == 0) begin
      parse_ph = PH_IDLE;
      return 1'b1;
    end
    parse_ph = PH_FHDR;
    return 1'b0;
  endfunction

  function automatic result_t classify_byte(input logic [7:0] b, input logic s);
    result_t     r;
    logic [4:0]  hs;
    logic [4:0]  c;
    logic [4:0]  k;
    logic [31:0] tag;
    logic [15:0] len16;
    logic [31:0] len;
    r            = '0;
    r.out_byte   = b;
    r.byte_class = CLS_SKIP;
    r.error_code = ERR_NONE;
    hs = eff_hdr_size();
    if (s) clear_parse();
    c = hdr_cnt;
    case (parse_ph)
      PH_HDR: begin
        r.byte_class = CLS_RECORD_HDR;
        if (c < 5'd4) rec_tag = rec_tag | (32'(b) << {c[1:0], 3'b000});
        else if (c < 5'd8) rec_left = rec_left | (32'(b) << {c[1:0], 3'b000});
        else if (c == FLAG_BYTE_POS && b[FLAG_COMP_BIT]) rec_skip = 1'b1;
        if ({1'b0, c} + 6'd1 >= {1'b0, hs}) begin
          if (rec_tag == TAG_GROUP) rec_skip = 1'b1;
          hdr_cnt = '0;
          if (rec_left == 0) begin
            r.record_end = 1'b1;
            parse_ph = PH_IDLE;
          end else begin
            parse_ph = rec_skip ? PH_SKIP : PH_FHDR;
          end
        end else begin
          hdr_cnt = c + 5'd1;
        end
      end
      PH_FHDR: begin
        if (c == 5'd0 && rec_left < FHDR_BYTES) begin
          // not even a bare field header left: flagged on a skip-class byte
          r.error_code = ERR_SHORT_FHDR;
          rec_left = rec_left - 32'd1;
          r.record_end = discard_rest();
        end else begin
          r.byte_class = CLS_FIELD_HDR;
          rec_left = rec_left - 32'd1;
          fhdr_shift = {b, fhdr_shift[47:8]};
          if (c == FHDR_LAST || c >= EXT_HDR_LAST) begin
            tag   = fhdr_shift[31:0];
            len16 = fhdr_shift[47:32];
            if (c == FHDR_LAST && tag == TAG_EXT && len16 == EXT_LEN) begin
              // extended size follows, then the real field header
              if (rec_left < EXT_TAIL_MIN) begin
                r.error_code = ERR_SHORT_EXT;
                r.record_end = discard_rest();
              end else begin
                ext_pending = 1'b1;
                ext_size    = '0;
                hdr_cnt     = EXT_SIZE_FIRST;
              end
            end else begin
              len = ext_pending ? ext_size : 32'(len16);
              fld_tag = tag;
              if (len > rec_left) begin
                r.error_code = ERR_OVERRUN;
                r.record_end = discard_rest();
              end else begin
                fld_left = len;
                if (len != 0) begin
                  hdr_cnt     = '0;
                  ext_pending = 1'b0;
                  parse_ph    = PH_PAY;
                end else begin
                  r.record_end = close_field();
                end
              end
            end
          end else begin
            if (c >= EXT_SIZE_FIRST && c <= EXT_SIZE_LAST) begin
              k = c - EXT_SIZE_FIRST;
              ext_size = ext_size | (32'(b) << {k[1:0], 3'b000});
            end
            hdr_cnt = c + 5'd1;
          end
        end
      end
      PH_PAY: begin
        r.byte_class  = CLS_PAYLOAD;
        r.field_type  = fld_tag;
        r.field_first = (c == 5'd0);
        hdr_cnt = 5'd1;
        if (fld_left != 0) fld_left = fld_left - 32'd1;
        if (rec_left != 0) rec_left = rec_left - 32'd1;
        if (fld_left == 0) begin
          r.field_last = 1'b1;
          r.record_end = close_field();
        end
      end
      PH_SKIP: begin
        if (rec_left != 0) rec_left = rec_left - 32'd1;
        if (rec_left == 0) begin
          r.record_end = 1'b1;
          parse_ph = PH_IDLE;
        end
      end
      default: parse_ph = PH_IDLE;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned fail_cnt      = 0;
  int unsigned beats_checked = 0;
  int unsigned bytes_sent    = 0;
  int unsigned records_sent  = 0;
  int unsigned n_parsed      = 0;
  int unsigned n_passed_over = 0;
  int unsigned n_empty       = 0;
  int unsigned n_malformed   = 0;
  int unsigned size_writes   = 0;
  int unsigned err_tally[4];
  int unsigned quiet_cycles  = 0;
  result_t     seen;
  result_t     head;

  function automatic string fmt(input result_t r);
    return $sformatf("byte %02h class %0d type %08h first %0b last %0b end %0b err %0d",
                     r.out_byte, r.byte_class, r.field_type, r.field_first,
                     r.field_last, r.record_end, r.error_code);
  endfunction

  task automatic note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // Receiver: random stall per cycle at the current rate.
  always @(posedge clk) out_ready <= ($urandom_range(99) >= out_stall_pct);

  // Result checker: every output beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen.out_byte    = out_byte;
      seen.byte_class  = byte_class;
      seen.field_type  = field_type;
      seen.field_first = field_first;
      seen.field_last  = field_last;
      seen.record_end  = record_end;
      seen.error_code  = error_code;
      beats_checked++;
      if (predicted.size() == 0) begin
        note_failure($sformatf("beat with nothing predicted: %s", fmt(seen)));
      end else begin
        head = predicted.pop_front();
        err_tally[head.error_code]++;
        if (seen.out_byte !== head.out_byte || seen.byte_class !== head.byte_class ||
            seen.field_type !== head.field_type || seen.field_first !== head.field_first ||
            seen.field_last !== head.field_last || seen.record_end !== head.record_end ||
            seen.error_code !== head.error_code)
          note_failure($sformatf("expected %s, got %s", fmt(head), fmt(seen)));
      end
    end
  end

  // Hang detection: any beat on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results owed",
               quiet_cycles, predicted.size());
      $display("[record_subfield_deframer] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plumbing
  // ---------------------------------------------------------------------------
  logic [7:0] body_q[$];       // record data under construction

  // One input beat; predicts its result once the block takes it.
  task automatic push_byte(input logic [7:0] b, input logic s);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    record_start <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted.insert(predicted.size(), classify_byte(b, s));
    bytes_sent++;
  endtask

  // Hold the input off until every predicted beat has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted.size() != 0) @(posedge clk);
  endtask

  task automatic write_header_size(input logic [4:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    hdr_size_reg = v;
    size_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic put_le(ref logic [7:0] q[$], input logic [31:0] v, input int unsigned n);
    for (int i = 0; i < n; i++) q.insert(q.size(), v[8*i +: 8]);
  endtask

  task automatic add_payload(input int unsigned n);
    repeat (n) body_q.insert(body_q.size(), 8'($urandom));
  endtask

  task automatic add_field(input logic [31:0] tag, input logic [15:0] len,
                           input int unsigned pay);
    put_le(body_q, tag, 4);
    put_le(body_q, 32'(len), 2);
    add_payload(pay);
  endtask

  // Extended size field, then the real header whose own length is a don't-care.
  task automatic add_ext_field(input logic [31:0] tag, input int unsigned n,
                               input logic [15:0] junk_len);
    put_le(body_q, TAG_EXT, 4);
    put_le(body_q, 32'(EXT_LEN), 2);
    put_le(body_q, n, 4);
    put_le(body_q, tag, 4);
    put_le(body_q, 32'(junk_len), 2);
    add_payload(n);
  endtask

  task automatic push_body();
    foreach (body_q[i]) push_byte(body_q[i], 1'b0);
    body_q.delete();
  endtask

  task automatic push_stray(input int unsigned n, input logic with_start);
    for (int i = 0; i < n; i++) push_byte(8'($urandom), with_start && i == 0);
  endtask

  // Record header sized for the current setting, then whatever is in body_q.
  task automatic send_record(input logic [31:0] tag, input logic [31:0] flags,
                             input logic [31:0] len, input logic with_start);
    logic [7:0] hdr_q[$];
    put_le(hdr_q, tag, 4);
    put_le(hdr_q, len, 4);
    put_le(hdr_q, flags, 4);
    while (hdr_q.size() < eff_hdr_size()) hdr_q.insert(hdr_q.size(), 8'($urandom));
    foreach (hdr_q[i]) push_byte(hdr_q[i], with_start && i == 0);
    push_body();
    records_sent++;
  endtask

  // Mostly short fields, a few long ones.
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(8);
    if (r < 95) return $urandom_range(40, 9);
    return $urandom_range(120, 41);
  endfunction

  task automatic build_fields();
    int unsigned nf;
    int unsigned pick;
    int unsigned n;
    logic [15:0] len16;
    nf = $urandom_range(4);
    repeat (nf) begin
      pick = $urandom_range(9);
      n    = pick_len();
      if (pick < 2) begin
        add_ext_field($urandom, n, 16'($urandom));
      end else if (pick == 2) begin
        // extended tag with a length other than four is just a field
        len16 = (n == 4) ? 16'd5 : 16'(n);
        add_field(TAG_EXT, len16, 32'(len16));
      end else begin
        add_field($urandom, 16'(n), n);
      end
    end
  endtask

  task automatic send_random_record();
    int unsigned kind;
    int          len;
    logic [31:0] tg;
    logic [31:0] flags;
    kind  = $urandom_range(99);
    tg    = $urandom;
    flags = $urandom & ~COMPRESSED_FLAG;
    if (kind < 60) begin
      build_fields();
      send_record(tg, flags, body_q.size(), 1'b1);
      n_parsed++;
    end else if (kind < 68) begin
      add_payload(pick_len());
      send_record(TAG_GROUP, $urandom, body_q.size(), 1'b1);
      n_passed_over++;
    end else if (kind < 76) begin
      add_payload(pick_len());
      send_record(tg, flags | COMPRESSED_FLAG, body_q.size(), 1'b1);
      n_passed_over++;
    end else if (kind < 80) begin
      send_record(tg, flags, 0, 1'b1);
      n_empty++;
    end else begin
      build_fields();
      case ($urandom_range(2))
        0: begin
          // declared size off from the real data by a few bytes
          len = int'(body_q.size()) + int'($urandom_range(16)) - 8;
          if (len < 0) len = 0;
        end
        1: begin
          // data cut short; the next record_start abandons it
          len = body_q.size();
          repeat ($urandom_range(body_q.size())) void'(body_q.pop_back());
        end
        default: begin
          body_q.delete();
          add_payload(pick_len());
          len = ($urandom_range(1)) ? body_q.size() : $urandom_range(40);
        end
      endcase
      // an occasional record with no start marker continues or strays
      send_record(tg, flags, 32'(len), $urandom_range(9) != 0);
      n_malformed++;
    end
    if ($urandom_range(9) < 2) push_stray($urandom_range(4, 1), 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner cases at the reset header size of 24.
  task automatic test_directed_cases();
    logic [31:0] tg;
    tg = 32'h4C4C_5546;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    // straight out of reset the bytes form a header with no start marker;
    // all-ones type and flags (compressed bit clear), zero size: empty record
    send_record(32'hFFFF_FFFF, ~COMPRESSED_FLAG, 0, 1'b0);
    // stray bytes between records
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    // one-byte field, empty field, payload at both byte extremes
    add_field(tg, 16'd1, 1);
    add_field(~tg, 16'd0, 0);
    add_field(32'h0, 16'd2, 0);
    body_q.insert(body_q.size(), 8'h00);
    body_q.insert(body_q.size(), 8'hFF);
    send_record(32'h0, 32'h0, body_q.size(), 1'b1);
    // group and compressed records pass their data over
    add_payload(5);
    send_record(TAG_GROUP, 32'h0, body_q.size(), 1'b1);
    add_payload(4);
    send_record(tg, COMPRESSED_FLAG, body_q.size(), 1'b1);
    // extended size then a normal field
    add_ext_field(tg, 3, 16'hFFFF);
    add_field(tg, 16'd1, 1);
    send_record(tg, 32'h0, body_q.size(), 1'b1);
    // header after an extended size looks extended too but must not chain
    add_ext_field(TAG_EXT, 2, EXT_LEN);
    send_record(tg, 32'h0, body_q.size(), 1'b1);
    // short field header with bytes left over, then on the record's last byte
    add_field(tg, 16'd0, 0);
    add_payload(3);
    send_record(tg, 32'h0, body_q.size(), 1'b1);
    add_field(tg, 16'd1, 1);
    add_payload(1);
    send_record(tg, 32'h0, body_q.size(), 1'b1);
    // short extended header
    put_le(body_q, TAG_EXT, 4);
    put_le(body_q, 32'(EXT_LEN), 2);
    add_payload(6);
    send_record(tg, 32'h0, body_q.size(), 1'b1);
    // overrun with data to discard, then overrun on the last byte
    add_field(tg, 16'd10, 3);
    send_record(tg, 32'h0, body_q.size(), 1'b1);
    add_field(32'hFFFF_FFFF, 16'hFFFF, 0);
    send_record(tg, 32'h0, body_q.size(), 1'b1);
    // abandoned mid-data, abandoned mid-header, then a clean record
    add_field(tg, 16'd8, 4);
    send_record(tg, 32'h0, 30, 1'b1);
    push_stray(7, 1'b1);
    add_field(tg, 16'd2, 2);
    send_record(tg, 32'h0, body_q.size(), 1'b1);
  endtask

  // Every clamp region of header_size, both ends included.
  task automatic test_header_size_sweep();
    logic [4:0] sizes[9];
    sizes = '{5'd0, 5'd19, HDR_SIZE_MIN, 5'd21, 5'd22, 5'd23, HDR_SIZE_MAX, 5'd25, 5'd31};
    in_idle_pct   = 20;
    out_stall_pct = 20;
    foreach (sizes[i]) begin
      write_header_size(sizes[i]);
      add_field($urandom, 16'd2, 2);
      send_record($urandom & ~COMPRESSED_FLAG, 32'h0, body_q.size(), 1'b1);
    end
  endtask

  // Sender stops mid-record until the block has fully drained.
  task automatic test_pause_mid_record();
    logic [31:0] tg;
    tg = $urandom;
    in_idle_pct   = 0;
    out_stall_pct = 63;
    write_header_size(HDR_SIZE_MAX);
    add_field(tg, 16'd6, 6);
    send_record(tg, 32'h0, 21, 1'b1);
    drain();
    add_field(tg, 16'd3, 3);
    push_body();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned n_bytes);
    int unsigned target;
    logic [4:0]  hs;
    case ($urandom_range(3))
      0:       hs = HDR_SIZE_MIN;
      1:       hs = HDR_SIZE_MAX;
      default: hs = 5'($urandom);
    endcase
    write_header_size(hs);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      if ($urandom_range(29) == 0) drain();
      send_random_record();
    end
  endtask

  initial begin
    hdr_size_reg = HDR_SIZE_RESET;
    clear_parse();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_header_size_sweep();
    test_pause_mid_record();
    test_random_traffic(0, 0, 80);
    test_random_traffic(63, 0, 80);
    test_random_traffic(0, 63, 80);
    test_random_traffic(26, 26, 80);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (predicted.size() != 0)
      note_failure($sformatf("%0d predicted beats never came out", predicted.size()));

    $display("run: %0d records over %0d bytes (%0d parsed, %0d passed over, %0d empty,",
             records_sent, bytes_sent, n_parsed, n_passed_over, n_empty);
    $display("run: %0d malformed), %0d header_size writes, %0d beats checked",
             n_malformed, size_writes, beats_checked);
    $display("run: short field header %0d, short ext header %0d, overrun %0d",
             err_tally[ERR_SHORT_FHDR], err_tally[ERR_SHORT_EXT], err_tally[ERR_OVERRUN]);
    if (fail_cnt == 0) begin
      $display("[record_subfield_deframer] OK");
    end else begin
      $display("[record_subfield_deframer] ERROR");
    end
    $finish;
  end

endmodule

### record_subfield_deframer.f
+incdir+design
design/rsd_pkg.sv
design/rsd_in_reg.sv
design/rsd_core.sv
design/rsd_out_reg.sv
design/record_subfield_deframer.sv
dv/record_subfield_deframer_test.sv
